// ===== sv/bn_pkg.sv =====
// Shared constants and types for the batch normalization block.
package bn_pkg;

  localparam int FEATURES_DEF  = 8;
  localparam int MAX_BATCH_DEF = 8;

  localparam logic [15:0] MOMENTUM_RESET = 16'd58982;
  localparam logic [32:0] EPS_Q16        = 33'd7;
  localparam logic [32:0] VAR_CAP        = 33'h0_7FFF_FFFF;

  // Operation codes of an input word.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_TRAIN = 2'd1;
  localparam logic [1:0] OP_INFER = 2'd2;

  // Shared multiplier operand width, divider dividend width.
  localparam int MUL_W = 34;
  localparam int DIV_W = 36;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SUM_RD,
    S_SUM_ACC,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_SQ_RD,
    S_SQ_SUB,
    S_SQ_MUL,
    S_SQ_ACC,
    S_VAR_GO,
    S_VAR_WAIT,
    S_BL_M1,
    S_BL_M2,
    S_BL_V1,
    S_BL_V2,
    S_BL_V3,
    S_RT_SQ,
    S_RT_V,
    S_RT_CMP,
    S_NM_RD,
    S_NM_D,
    S_NM_MUL,
    S_NM_OUT
  } state_t;

endpackage

// ===== sv/bn_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module bn_div #(
  parameter int DW = 36,
  parameter int VW = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int KW = $clog2(DW + 1);

  logic [DW-1:0] q;
  logic [VW-1:0] rem;
  logic [KW-1:0] cnt;
  logic          run;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          ge;

  assign trial    = {rem, q[DW-1]};
  assign diff     = trial - {1'b0, divisor};
  assign ge       = (trial >= {1'b0, divisor});
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= KW'(DW);
      end else if (run) begin
        cnt <= cnt - KW'(1);
        if (cnt == KW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
    end else if (run) begin
      q   <= {q[DW-2:0], ge};
      rem <= ge ? diff[VW-1:0] : trial[VW-1:0];
    end
  end

endmodule

// ===== sv/batch_norm_forward.sv =====
// Batch normalization forward pass: batch store, statistics sequencer, normalizer.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+----------------------------------------------
//   in       | in_valid / in_stall   | operation feature sample shift_value
//            |                       | scale_value end_of_batch
//   out      | out_valid / out_stall | norm_value row channel last overflow
//   cfg      | cfg_write_en          | cfg_write_data (momentum, Q0.16)
//
// Write words and training words that do not close a batch are taken without stalling the input.
// A batch close runs per channel: row sum, mean divide, squared deviations,
// variance divide, running-stat blend and the 16-step inverse root on the one
// shared multiplier; then it emits one word per row and channel, row by row.
// An inference word for a known feature runs the inverse root loop on the running variance.
// rst is synchronous; it clears tables, running stats and the row count.
// Output stalls hold the result register; the sequencer waits on it.
module batch_norm_forward
  import bn_pkg::*;
#(
  parameter int FEATURES  = FEATURES_DEF,
  parameter int MAX_BATCH = MAX_BATCH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_en,
  input  logic [15:0]        cfg_write_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         operation,
  input  logic [2:0]         feature,
  input  logic signed [15:0] sample,
  input  logic signed [15:0] shift_value,
  input  logic signed [15:0] scale_value,
  input  logic               end_of_batch,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] norm_value,
  output logic [2:0]         row,
  output logic [2:0]         channel,
  output logic               last,
  output logic               overflow
);

  localparam int CW    = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int RW    = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
  localparam int NW    = $clog2(MAX_BATCH + 1);
  localparam int DEPTH = MAX_BATCH * FEATURES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  state_t state, state_next;

  // configuration and persistent state
  logic [15:0]        momentum;
  logic [16:0]        mom_b;
  logic [NW-1:0]      rows;
  logic               ovf;
  logic signed [15:0] shift_tab [FEATURES];
  logic signed [15:0] scale_tab [FEATURES];
  logic signed [31:0] rmean     [FEATURES];
  logic [31:0]        rvar      [FEATURES];
  logic signed [31:0] bmean     [FEATURES];
  logic [15:0]        invs      [FEATURES];

  // batch store
  logic [15:0]   store [DEPTH];
  logic [15:0]   rd_data;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;

  // sequencer working registers
  logic [CW-1:0]      c;
  logic [RW-1:0]      r;
  logic [NW-1:0]      n_lat;
  logic               ovf_lat;
  logic               is_batch;
  logic               inf_bad;
  logic signed [15:0] x_lat;
  logic [2:0]         ch_lat;
  logic signed [27:0] sum;
  logic [51:0]        sq;
  logic signed [31:0] mean_r;
  logic [31:0]        var_r;
  logic signed [25:0] dreg;
  logic signed [67:0] prod;
  logic signed [67:0] acc;
  logic [15:0]        rt_r;
  logic [3:0]         rt_bit;
  logic [31:0]        rt_v;

  // combinational helpers
  logic                     accept;
  logic                     feat_ok;
  logic [CW-1:0]            fidx;
  logic                     full;
  logic                     advance;
  logic [NW-1:0]            rows_new;
  logic                     row_last;
  logic                     ch_last;
  logic                     slot_free;
  logic                     out_load;
  logic                     div_start;
  logic                     div_done;
  logic [DIV_W-1:0]         div_dividend;
  logic [DIV_W-1:0]         div_q;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic [15:0]              rt_t;
  logic                     rt_fit;
  logic [15:0]              rt_r_new;
  logic [CW-1:0]            nch;
  logic signed [31:0]       mean_sel;
  logic [15:0]              inv_sel;
  logic signed [15:0]       x_sel;
  logic signed [32:0]       d33;
  logic signed [67:0]       rnd;
  logic signed [42:0]       yq;
  logic signed [15:0]       y_sat;
  logic signed [67:0]       blend;
  logic [27:0]              sum_abs;
  logic signed [31:0]       mean_div;
  logic [32:0]              var_eps;
  logic [32:0]              rvar_eps;
  logic [31:0]              var_cap;
  logic [31:0]              rvar_cap;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign feat_ok  = ({1'b0, feature} < 4'(FEATURES));
  assign fidx     = feature[CW-1:0];
  assign full     = (rows >= NW'(MAX_BATCH));
  assign advance  = (feature == 3'(FEATURES - 1)) || end_of_batch;
  assign rows_new = full ? rows : (advance ? rows + NW'(1) : rows);
  assign mom_b    = 17'h10000 - {1'b0, momentum};

  assign row_last  = ((NW'(r) + NW'(1)) == n_lat);
  assign ch_last   = (c == CW'(FEATURES - 1));
  assign slot_free = !out_valid || !out_stall;

  assign rd_addr = AW'(r) * AW'(FEATURES) + AW'(c);
  assign wr_addr = AW'(rows) * AW'(FEATURES) + AW'(fidx);

  // inverse root trial bit
  assign rt_t     = rt_r | (16'h1 << rt_bit);
  assign rt_fit   = (prod <= (68'sd1 <<< 34));
  assign rt_r_new = rt_fit ? rt_t : rt_r;

  // root input: variance plus epsilon, capped
  assign var_eps  = {1'b0, div_q[31:0]} + EPS_Q16;
  assign var_cap  = (var_eps > VAR_CAP) ? VAR_CAP[31:0] : var_eps[31:0];
  assign rvar_eps = {1'b0, rvar[fidx]} + EPS_Q16;
  assign rvar_cap = (rvar_eps > VAR_CAP) ? VAR_CAP[31:0] : rvar_eps[31:0];

  // normalizer operand select
  assign nch      = is_batch ? c : ch_lat[CW-1:0];
  assign mean_sel = is_batch ? bmean[c] : rmean[nch];
  assign inv_sel  = is_batch ? invs[c] : rt_r;
  assign x_sel    = is_batch ? $signed(rd_data) : x_lat;
  assign d33      = {{9{x_sel[15]}}, x_sel, 8'b0} - {mean_sel[31], mean_sel};

  // round, shift back to Q8.8, add shift, saturate
  assign rnd = prod + (68'sd1 <<< 24);
  assign yq  = $signed(rnd[67:25]) + {{27{shift_tab[nch][15]}}, shift_tab[nch]};
  always_comb begin
    if (yq > 43'sd32767) begin
      y_sat = 16'sh7FFF;
    end else if (yq < -43'sd32768) begin
      y_sat = -16'sh8000;
    end else begin
      y_sat = yq[15:0];
    end
  end

  assign blend    = acc + prod;
  assign sum_abs  = sum[27] ? 28'(-sum) : 28'(sum);
  assign mean_div = sum[27] ? -$signed(div_q[31:0]) : $signed(div_q[31:0]);

  assign div_dividend = (state == S_MEAN_GO) ? DIV_W'(sum_abs) : sq[51:16];

  bn_div #(
    .DW (DIV_W),
    .VW (NW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (n_lat),
    .done     (div_done),
    .quotient (div_q)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && operation == OP_TRAIN && end_of_batch) begin
          state_next = S_SUM_RD;
        end else if (accept && operation == OP_INFER) begin
          state_next = feat_ok ? S_RT_SQ : S_NM_OUT;
        end
      end
      S_SUM_RD:    state_next = S_SUM_ACC;
      S_SUM_ACC:   state_next = row_last ? S_MEAN_GO : S_SUM_RD;
      S_MEAN_GO:   state_next = S_MEAN_WAIT;
      S_MEAN_WAIT: state_next = div_done ? S_SQ_RD : S_MEAN_WAIT;
      S_SQ_RD:     state_next = S_SQ_SUB;
      S_SQ_SUB:    state_next = S_SQ_MUL;
      S_SQ_MUL:    state_next = S_SQ_ACC;
      S_SQ_ACC:    state_next = row_last ? S_VAR_GO : S_SQ_RD;
      S_VAR_GO:    state_next = S_VAR_WAIT;
      S_VAR_WAIT:  state_next = div_done ? S_BL_M1 : S_VAR_WAIT;
      S_BL_M1:     state_next = S_BL_M2;
      S_BL_M2:     state_next = S_BL_V1;
      S_BL_V1:     state_next = S_BL_V2;
      S_BL_V2:     state_next = S_BL_V3;
      S_BL_V3:     state_next = S_RT_SQ;
      S_RT_SQ:     state_next = S_RT_V;
      S_RT_V:      state_next = S_RT_CMP;
      S_RT_CMP: begin
        if (rt_bit != 4'd0) begin
          state_next = S_RT_SQ;
        end else if (!is_batch) begin
          state_next = S_NM_D;
        end else begin
          state_next = ch_last ? S_NM_RD : S_SUM_RD;
        end
      end
      S_NM_RD:  state_next = S_NM_D;
      S_NM_D:   state_next = S_NM_MUL;
      S_NM_MUL: state_next = S_NM_OUT;
      S_NM_OUT: begin
        if (slot_free) begin
          if (!is_batch || (row_last && ch_last)) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_NM_RD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs: multiplier operands, divider start, result load
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      S_MEAN_GO: div_start = 1'b1;
      S_VAR_GO:  div_start = 1'b1;
      S_SQ_MUL: begin
        mul_a = {{8{dreg[25]}}, dreg};
        mul_b = {{8{dreg[25]}}, dreg};
      end
      S_BL_M1: begin
        mul_a = {18'b0, momentum};
        mul_b = {{2{rmean[c][31]}}, rmean[c]};
      end
      S_BL_M2: begin
        mul_a = {17'b0, mom_b};
        mul_b = {{2{mean_r[31]}}, mean_r};
      end
      S_BL_V1: begin
        mul_a = {18'b0, momentum};
        mul_b = {2'b0, rvar[c]};
      end
      S_BL_V2: begin
        mul_a = {17'b0, mom_b};
        mul_b = {2'b0, var_r};
      end
      S_RT_SQ: begin
        mul_a = {18'b0, rt_t};
        mul_b = {18'b0, rt_t};
      end
      S_RT_V: begin
        mul_a = {2'b0, prod[31:0]};
        mul_b = {2'b0, rt_v};
      end
      S_NM_D: begin
        mul_a = {{18{scale_tab[nch][15]}}, scale_tab[nch]};
        mul_b = {18'b0, inv_sel};
      end
      S_NM_MUL: begin
        mul_a = {{8{dreg[25]}}, dreg};
        mul_b = prod[MUL_W-1:0];
      end
      S_NM_OUT: out_load = slot_free;
      default: ;
    endcase
  end

  // control state, tables and running statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      momentum  <= MOMENTUM_RESET;
      rows      <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < FEATURES; i++) begin
        shift_tab[i] <= '0;
        scale_tab[i] <= '0;
        rmean[i]     <= '0;
        rvar[i]      <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_write_en) begin
        momentum <= cfg_write_data;
      end
      if (accept && operation == OP_WRITE && feat_ok) begin
        shift_tab[fidx] <= shift_value;
        scale_tab[fidx] <= scale_value;
      end
      if (accept && operation == OP_TRAIN) begin
        if (end_of_batch) begin
          rows <= '0;
          ovf  <= 1'b0;
        end else begin
          rows <= rows_new;
          if (full) begin
            ovf <= 1'b1;
          end
        end
      end
      if (state == S_BL_V1) begin
        rmean[c] <= blend[47:16];
      end
      if (state == S_BL_V3) begin
        rvar[c] <= blend[47:16];
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // batch store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (accept && operation == OP_TRAIN && !full && feat_ok) begin
      store[wr_addr] <= sample;
    end
    rd_data <= store[rd_addr];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    // product held while the result waits for a free output slot
    if (state != S_NM_OUT) begin
      prod <= mul_a * mul_b;
    end
    case (state)
      S_IDLE: begin
        if (accept && operation == OP_TRAIN && end_of_batch) begin
          n_lat    <= rows_new;
          ovf_lat  <= ovf || full;
          is_batch <= 1'b1;
          c        <= '0;
          r        <= '0;
          sum      <= '0;
        end
        if (accept && operation == OP_INFER) begin
          x_lat    <= sample;
          ch_lat   <= feature;
          ovf_lat  <= ovf;
          is_batch <= 1'b0;
          inf_bad  <= !feat_ok;
          rt_v     <= rvar_cap;
          rt_r     <= '0;
          rt_bit   <= 4'd15;
        end
      end
      S_SUM_ACC: begin
        sum <= sum + {{4{rd_data[15]}}, rd_data, 8'b0};
        r   <= row_last ? '0 : r + RW'(1);
      end
      S_MEAN_WAIT: begin
        if (div_done) begin
          mean_r   <= mean_div;
          bmean[c] <= mean_div;
          sq       <= '0;
        end
      end
      S_SQ_SUB: dreg <= {{2{rd_data[15]}}, rd_data, 8'b0} - {{2{mean_r[31]}}, mean_r[23:0]};
      S_SQ_ACC: begin
        sq <= sq + prod[51:0];
        r  <= row_last ? '0 : r + RW'(1);
      end
      S_VAR_WAIT: begin
        if (div_done) begin
          var_r  <= div_q[31:0];
          rt_v   <= var_cap;
          rt_r   <= '0;
          rt_bit <= 4'd15;
        end
      end
      S_BL_M2: acc <= prod;
      S_BL_V2: acc <= prod;
      S_RT_CMP: begin
        rt_r   <= rt_r_new;
        rt_bit <= rt_bit - 4'd1;
        if (rt_bit == 4'd0 && is_batch) begin
          invs[c] <= rt_r_new;
          sum     <= '0;
          r       <= '0;
          c       <= ch_last ? '0 : c + CW'(1);
        end
      end
      S_NM_D: dreg <= d33[25:0];
      S_NM_OUT: begin
        if (slot_free && is_batch) begin
          if (ch_last) begin
            c <= '0;
            r <= r + RW'(1);
          end else begin
            c <= c + CW'(1);
          end
        end
      end
      default: ;
    endcase
    if (out_load) begin
      norm_value <= inf_bad && !is_batch ? 16'sd0 : y_sat;
      row        <= is_batch ? 3'(r) : 3'd0;
      channel    <= is_batch ? 3'(c) : ch_lat;
      last       <= !is_batch || (row_last && ch_last);
      overflow   <= ovf_lat;
    end
  end

endmodule

// ===== sv/bn_check.sv =====
// Port-level checks for the batch normalization block, bound to the top level.
module bn_check
  import bn_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic [1:0]         operation,
  input logic               end_of_batch,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] norm_value,
  input logic [2:0]         row,
  input logic [2:0]         channel,
  input logic               last,
  input logic               overflow
);

  a_infer_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && operation == OP_INFER) |=> in_stall)
    else $error("inference word did not make the block busy");

  a_batch_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && operation == OP_TRAIN && end_of_batch) |=> in_stall)
    else $error("batch close did not make the block busy");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(norm_value) && $stable(row)
      && $stable(channel) && $stable(last) && $stable(overflow)))
    else $error("stalled result word changed");

  a_reset: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("block not idle after reset");

endmodule

bind batch_norm_forward bn_check u_bn_check (.*);
